// ----- rtl/matrix_scale_and_matvec_defines.svh -----
// assertion macros for the matrix scale and matrix-vector block
// expects signals named clock and reset in the module that uses them
`ifndef MATRIX_SCALE_AND_MATVEC_DEFINES_SVH
`define MATRIX_SCALE_AND_MATVEC_DEFINES_SVH
`ifndef SYNTH
`define MSM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MSM_ASSERT_NEVER(lbl, cond, msg) `MSM_ASSERT(lbl, !(cond), msg)
`else
`define MSM_ASSERT(lbl, prop, msg)
`define MSM_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/msm_pkg.sv -----
// shared types, constants and arithmetic helpers of the matrix scale / matvec block
// no dependencies; used by matrix_scale_and_matvec
`default_nettype none

package msm_pkg;

   // matrix geometry
   localparam int MAX_ROWS  = 16;
   localparam int MAX_COLS  = 16;
   localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W    = $clog2(MAX_COLS + 1);
   localparam int DATA_W    = 32;

   // register file
   localparam int   CSR_AW     = 3;
   localparam logic REG_ROWS   = 1'b0;
   localparam logic REG_COLS   = 1'b1;
   localparam logic [4:0] ROWS_RESET = 5'd16;
   localparam logic [4:0] COLS_RESET = 5'd16;

   // request operations
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_SCALE  = 2'd2,
      OP_VECTOR = 2'd3
   } op_type;

   typedef struct packed {
      op_type              operation;
      logic [3:0]          row_index;
      logic [3:0]          column_index;
      logic signed [31:0]  operand_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0]  data_value;
      logic [3:0]          result_row;
      logic                last;
      logic                status;
   } rsp_payload_type;

   // bookkeeping that travels down the arithmetic pipeline
   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [ROW_W-1:0]    row;
      logic                first;
      logic                last_col;
      logic                last_row;
   } pipe_meta_type;

   // flat memory address of element (r, c)
   function automatic logic [ADDR_W-1:0] mat_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_COLS + int'(c));
   endfunction

   // q16.16 product scaling: divide by 2^16 toward zero, saturate to 32 bits
   function automatic logic signed [31:0] q_round_sat(input logic signed [63:0] p);
      logic signed [63:0] biased;
      logic signed [47:0] shifted;
      biased  = p + (p[63] ? 64'sd65535 : 64'sd0);
      shifted = biased[63:16];
      if (shifted > 48'sh0000_7FFF_FFFF) begin
         return 32'sh7FFF_FFFF;
      end else if (shifted < 48'shFFFF_8000_0000) begin
         return 32'sh8000_0000;
      end
      return shifted[31:0];
   endfunction

   // saturating 32-bit add
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return s[31:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/msm_ram.sv -----
// generic simple dual-port ram, one write port, one registered read port
// no dependencies; used for the matrix and vector stores
`default_nettype none

module msm_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read, read data holds while re is low
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/matrix_scale_and_matvec.sv -----
// top level of the matrix scale and matrix-vector unit
// depends on msm_pkg, msm_ram and matrix_scale_and_matvec_defines.svh
//
//   port group   role      handshake                 carries
//   req_*        input     req_valid / req_stall     msm_pkg::req_payload_type
//   rsp_*        output    rsp_valid / rsp_stall     msm_pkg::rsp_payload_type
//   csr_*        config    apb write psel&penable    rows_in_use @0, cols_in_use @4
//
// write, read or out-of-range request: the response lands in the output register
// vector element that is not the last: stored in the vector memory, no response
// scale and product: one matrix element per cycle through the single matrix memory read port,
//   while no stalled response holds the pipeline
// after reset and after every register write a clearing pass zeroes all MAX_ROWS*MAX_COLS
//   entries (256) of the matrix memory, with req_stall high
// a stalled response freezes the scale and product pipeline; req_stall stays high until it is done
`default_nettype none
`include "matrix_scale_and_matvec_defines.svh"

module matrix_scale_and_matvec (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire msm_pkg::req_payload_type   req_payload,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output msm_pkg::rsp_payload_type        rsp_payload,
   // register port
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [msm_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic      [31:0]                csr_prdata,
   output logic                            csr_pready
);

   import msm_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESP,
      ST_SCALE,
      ST_MATVEC
   } state_type;

   // control registers
   state_type            state_ff,       state_in;
   logic [4:0]           rows_cfg_ff,    rows_cfg_in;
   logic [4:0]           cols_cfg_ff,    cols_cfg_in;
   logic                 collapsed_ff,   collapsed_in;
   logic [ADDR_W-1:0]    clr_cnt_ff,     clr_cnt_in;
   logic                 resp_read_ff,   resp_read_in;
   logic                 resp_status_ff, resp_status_in;
   logic                 issuing_ff,     issuing_in;
   logic [ROW_W-1:0]     row_ff,         row_in;
   logic [COL_W-1:0]     col_ff,         col_in;
   logic                 p1_valid_ff,    p1_valid_in;
   logic                 p2_valid_ff,    p2_valid_in;
   logic                 p3_valid_ff,    p3_valid_in;
   logic                 rsp_valid_ff,   rsp_valid_in;

   // payload registers
   logic signed [31:0]   factor_ff,      factor_in;
   pipe_meta_type        p1_meta_ff,     p1_meta_in;
   pipe_meta_type        p2_meta_ff,     p2_meta_in;
   pipe_meta_type        p3_meta_ff,     p3_meta_in;
   logic signed [63:0]   p2_prod_ff,     p2_prod_in;
   logic signed [31:0]   p3_q_ff,        p3_q_in;
   logic signed [31:0]   acc_ff,         acc_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   // memory ports
   logic                 m_we, m_re;
   logic [ADDR_W-1:0]    m_waddr, m_raddr;
   logic [DATA_W-1:0]    m_wdata, m_rdata;
   logic                 v_we, v_re;
   logic [COL_W-1:0]     v_waddr, v_raddr;
   logic [DATA_W-1:0]    v_rdata;

   // decoded request and helpers
   logic                 cfg_write;
   logic                 req_accept;
   logic                 adv;
   logic [RCNT_W-1:0]    rows_eff;
   logic [CCNT_W-1:0]    cols_eff;
   logic                 row_ok, col_ok, in_range;
   logic                 vec_last;
   logic [ROW_W-1:0]     req_row;
   logic [COL_W-1:0]     req_col;
   logic [ADDR_W-1:0]    req_addr;
   logic                 issue;
   logic                 issue_row_last, issue_col_last;
   logic                 drained;
   logic                 emit;
   logic signed [31:0]   mul_a, mul_b;
   logic signed [63:0]   prod;
   logic signed [31:0]   acc_sum;

   // matrix and vector stores
   msm_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_matrix_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .re    (m_re),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   msm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_vector_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (req_payload.operand_value),
      .re    (v_re),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   // register port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ROWS) ? 32'(rows_cfg_ff) : 32'(cols_cfg_ff);

   // handshakes
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid & ~req_stall;
   assign adv         = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // rows and columns in effect
   always_comb begin
      if (rows_cfg_ff == 5'd0) begin
         rows_eff = RCNT_W'(1);
      end else if (32'(rows_cfg_ff) > MAX_ROWS) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(rows_cfg_ff);
      end
      if (collapsed_ff || cols_cfg_ff == 5'd0) begin
         cols_eff = CCNT_W'(1);
      end else if (32'(cols_cfg_ff) > MAX_COLS) begin
         cols_eff = CCNT_W'(MAX_COLS);
      end else begin
         cols_eff = CCNT_W'(cols_cfg_ff);
      end
   end

   // request decode
   assign row_ok   = 32'(req_payload.row_index) < 32'(rows_eff);
   assign col_ok   = 32'(req_payload.column_index) < 32'(cols_eff);
   assign in_range = row_ok & col_ok;
   assign vec_last = 32'(req_payload.column_index) == 32'(cols_eff) - 32'd1;
   assign req_row  = ROW_W'(req_payload.row_index);
   assign req_col  = COL_W'(req_payload.column_index);
   assign req_addr = mat_addr(req_row, req_col);

   // element walk for scale and product
   assign issue          = issuing_ff & adv;
   assign issue_row_last = 32'(row_ff) == 32'(rows_eff) - 32'd1;
   assign issue_col_last = 32'(col_ff) == 32'(cols_eff) - 32'd1;
   assign drained        = ~issuing_ff & ~p1_valid_ff & ~p2_valid_ff & ~p3_valid_ff;

   // datapath: multiply, then scale down, then accumulate for the product
   assign mul_a   = m_rdata;
   assign mul_b   = (state_ff == ST_MATVEC) ? signed'(v_rdata) : factor_ff;
   assign prod    = 64'(mul_a) * 64'(mul_b);
   assign acc_sum = sat_add(p3_meta_ff.first ? 32'sd0 : acc_ff, p3_q_ff);
   assign emit    = (state_ff == ST_MATVEC) & adv & p3_valid_ff & p3_meta_ff.last_col;

   // matrix memory ports
   always_comb begin
      m_we    = 1'b0;
      m_waddr = req_addr;
      m_wdata = req_payload.operand_value;
      case (state_ff)
         ST_CLEAR: begin
            m_we    = 1'b1;
            m_waddr = clr_cnt_ff;
            m_wdata = '0;
         end
         ST_IDLE: begin
            m_we = req_accept & (req_payload.operation == OP_WRITE) & in_range;
         end
         ST_SCALE: begin
            m_we    = adv & p3_valid_ff;
            m_waddr = p3_meta_ff.addr;
            m_wdata = p3_q_ff;
         end
         ST_MATVEC: begin
            m_we    = emit;
            m_waddr = mat_addr(p3_meta_ff.row, COL_W'(0));
            m_wdata = acc_sum;
         end
         default: begin
            m_we = 1'b0;
         end
      endcase
      m_re    = (state_ff == ST_IDLE) ? req_accept : adv;
      m_raddr = (state_ff == ST_IDLE) ? req_addr : mat_addr(row_ff, col_ff);
   end

   // vector memory ports
   assign v_we    = req_accept & (req_payload.operation == OP_VECTOR) & col_ok;
   assign v_waddr = req_col;
   assign v_re    = adv;
   assign v_raddr = col_ff;

   // next state
   always_comb begin
      state_in       = state_ff;
      rows_cfg_in    = rows_cfg_ff;
      cols_cfg_in    = cols_cfg_ff;
      collapsed_in   = collapsed_ff;
      clr_cnt_in     = clr_cnt_ff;
      resp_read_in   = resp_read_ff;
      resp_status_in = resp_status_ff;
      issuing_in     = issuing_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      p1_valid_in    = p1_valid_ff;
      p2_valid_in    = p2_valid_ff;
      p3_valid_in    = p3_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      factor_in      = factor_ff;
      p1_meta_in     = p1_meta_ff;
      p2_meta_in     = p2_meta_ff;
      p3_meta_in     = p3_meta_ff;
      p2_prod_in     = p2_prod_ff;
      p3_q_in        = p3_q_ff;
      acc_in         = acc_ff;
      rsp_payload_in = rsp_payload_ff;

      // sequencer
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(MEM_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_payload.operation) inside
                  OP_WRITE, OP_READ: begin
                     state_in       = ST_RESP;
                     resp_read_in   = (req_payload.operation == OP_READ) & in_range;
                     resp_status_in = ~in_range;
                  end
                  OP_SCALE: begin
                     state_in   = ST_SCALE;
                     factor_in  = req_payload.operand_value;
                     issuing_in = 1'b1;
                     row_in     = '0;
                     col_in     = '0;
                  end
                  OP_VECTOR: begin
                     if (!col_ok) begin
                        state_in       = ST_RESP;
                        resp_read_in   = 1'b0;
                        resp_status_in = 1'b1;
                     end else if (vec_last) begin
                        state_in   = ST_MATVEC;
                        issuing_in = 1'b1;
                        row_in     = '0;
                        col_in     = '0;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RESP: begin
            if (adv) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCALE: begin
            if (drained) begin
               state_in       = ST_RESP;
               resp_read_in   = 1'b0;
               resp_status_in = 1'b0;
            end
         end
         ST_MATVEC: begin
            if (drained) begin
               state_in     = ST_IDLE;
               collapsed_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // element walk and pipeline advance
      if (adv) begin
         if (issue) begin
            if (issue_col_last) begin
               col_in = '0;
               if (issue_row_last) begin
                  issuing_in = 1'b0;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         p1_valid_in         = issue;
         p1_meta_in.addr     = mat_addr(row_ff, col_ff);
         p1_meta_in.row      = row_ff;
         p1_meta_in.first    = (col_ff == '0);
         p1_meta_in.last_col = issue_col_last;
         p1_meta_in.last_row = issue_row_last;
         p2_valid_in         = p1_valid_ff;
         p2_meta_in          = p1_meta_ff;
         p2_prod_in          = prod;
         p3_valid_in         = p2_valid_ff;
         p3_meta_in          = p2_meta_ff;
         p3_q_in             = q_round_sat(p2_prod_ff);
         if (p3_valid_ff) begin
            acc_in = acc_sum;
         end
      end

      // output register
      if (emit) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.data_value = acc_sum;
         rsp_payload_in.result_row = 4'(p3_meta_ff.row);
         rsp_payload_in.last       = p3_meta_ff.last_row;
         rsp_payload_in.status     = 1'b0;
      end else if (state_ff == ST_RESP && adv) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.data_value = resp_read_ff ? signed'(m_rdata) : 32'sd0;
         rsp_payload_in.result_row = 4'd0;
         rsp_payload_in.last       = 1'b1;
         rsp_payload_in.status     = resp_status_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register write: new geometry, fresh cleared matrix
      if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_ROWS: rows_cfg_in = csr_pwdata[4:0];
            REG_COLS: cols_cfg_in = csr_pwdata[4:0];
            default:  rows_cfg_in = rows_cfg_ff;
         endcase
         state_in     = ST_CLEAR;
         clr_cnt_in   = '0;
         collapsed_in = 1'b0;
         issuing_in   = 1'b0;
         p1_valid_in  = 1'b0;
         p2_valid_in  = 1'b0;
         p3_valid_in  = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         rows_cfg_ff    <= ROWS_RESET;
         cols_cfg_ff    <= COLS_RESET;
         collapsed_ff   <= 1'b0;
         clr_cnt_ff     <= '0;
         resp_read_ff   <= 1'b0;
         resp_status_ff <= 1'b0;
         issuing_ff     <= 1'b0;
         row_ff         <= '0;
         col_ff         <= '0;
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         p3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rows_cfg_ff    <= rows_cfg_in;
         cols_cfg_ff    <= cols_cfg_in;
         collapsed_ff   <= collapsed_in;
         clr_cnt_ff     <= clr_cnt_in;
         resp_read_ff   <= resp_read_in;
         resp_status_ff <= resp_status_in;
         issuing_ff     <= issuing_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         p1_valid_ff    <= p1_valid_in;
         p2_valid_ff    <= p2_valid_in;
         p3_valid_ff    <= p3_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      factor_ff      <= factor_in;
      p1_meta_ff     <= p1_meta_in;
      p2_meta_ff     <= p2_meta_in;
      p3_meta_ff     <= p3_meta_in;
      p2_prod_ff     <= p2_prod_in;
      p3_q_ff        <= p3_q_in;
      acc_ff         <= acc_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // checks
   `MSM_ASSERT(a_pipe_in_walk, p3_valid_ff |-> (state_ff == ST_SCALE || state_ff == ST_MATVEC), "pipeline busy outside scale or product")
   `MSM_ASSERT_NEVER(a_no_write_in_resp, state_ff == ST_RESP && m_we, "matrix write while a response is pending")
   `MSM_ASSERT_NEVER(a_no_issue_in_clear, state_ff == ST_CLEAR && p1_valid_ff, "element walk during clearing pass")
   `MSM_ASSERT(a_collapse_after_product, $rose(collapsed_ff) |-> $past(state_ff == ST_MATVEC), "matrix collapsed without a product")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for matrix_scale_and_matvec: directed and random requests, checked against
// an in-bench model of the matrix store, scaling and saturating q16.16 dot products
// depends on msm_pkg and the matrix_scale_and_matvec rtl
`timescale 1ns / 100ps

module tb_top;
   import msm_pkg::*;

   localparam logic [CSR_AW-1:0] ROWS_ADDR = CSR_AW'(4 * REG_ROWS);
   localparam logic [CSR_AW-1:0] COLS_ADDR = CSR_AW'(4 * REG_COLS);
   // settle time after the last expected response
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES = 9;
   localparam int PHASE_REQUESTS = 18;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // model of the block state
   logic signed [31:0] matrix_model [MAX_ROWS*MAX_COLS];
   logic signed [31:0] vector_model [MAX_COLS];
   logic [MAX_COLS-1:0] vector_written = '0;
   logic collapsed = 1'b0;
   logic [4:0] rows_reg = ROWS_RESET;
   logic [4:0] cols_reg = COLS_RESET;

   rsp_payload_type expected_rsp [$];
   rsp_payload_type wanted;
   int fail_count = 0;
   bit steady = 1'b0;

   matrix_scale_and_matvec uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // random response backpressure
   always @(negedge clock) begin
      if (reset || steady) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 10);
   end

   // saturate to the signed 32-bit range
   function automatic logic signed [31:0] clamp_q(input longint v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // q16.16 product, truncated toward zero
   function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return clamp_q(prod / 64'sd65536);
   endfunction

   function automatic int rows_eff();
      if (rows_reg == 0) return 1;
      return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
   endfunction

   function automatic int cols_eff();
      if (collapsed || cols_reg == 0) return 1;
      return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
   endfunction

   // apply one request to the model and queue the responses it causes
   function automatic void predict_request(input req_payload_type rq);
      int nr, nc, r, c;
      logic signed [31:0] acc;
      rsp_payload_type rs;
      nr = rows_eff();
      nc = cols_eff();
      r = rq.row_index;
      c = rq.column_index;
      rs = '0;
      rs.last = 1'b1;
      case (rq.operation)
         OP_WRITE, OP_READ: begin
            if (r >= nr || c >= nc) rs.status = 1'b1;
            else if (rq.operation == OP_WRITE) matrix_model[r*MAX_COLS + c] = rq.operand_value;
            else rs.data_value = matrix_model[r*MAX_COLS + c];
            expected_rsp.push_back(rs);
         end
         OP_SCALE: begin
            for (int i = 0; i < nr; i++)
               for (int j = 0; j < nc; j++)
                  matrix_model[i*MAX_COLS + j] = q_mul(matrix_model[i*MAX_COLS + j],
                                                       rq.operand_value);
            expected_rsp.push_back(rs);
         end
         default: begin
            if (c >= nc) begin
               rs.status = 1'b1;
               expected_rsp.push_back(rs);
            end else begin
               vector_model[c] = rq.operand_value;
               vector_written[c] = 1'b1;
               // last position completes the vector: one dot product per row
               if (c == nc - 1) begin
                  for (int i = 0; i < nr; i++) begin
                     acc = '0;
                     for (int j = 0; j < nc; j++)
                        acc = clamp_q(longint'(acc) +
                                      longint'(q_mul(matrix_model[i*MAX_COLS + j],
                                                     vector_model[j])));
                     matrix_model[i*MAX_COLS] = acc;
                     rs.data_value = acc;
                     rs.result_row = 4'(i);
                     rs.last = (i == nr - 1);
                     expected_rsp.push_back(rs);
                  end
                  collapsed = 1'b1;
               end
            end
         end
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("response with none expected: data_value %0d result_row %0d",
                   rsp_payload.data_value, rsp_payload.result_row);
            fail_count++;
         end else begin
            wanted = expected_rsp.pop_front();
            if (rsp_payload.data_value !== wanted.data_value) begin
               $error("data_value: expected %0d, got %0d", wanted.data_value,
                      rsp_payload.data_value);
               fail_count++;
            end
            if (rsp_payload.result_row !== wanted.result_row) begin
               $error("result_row: expected %0d, got %0d", wanted.result_row,
                      rsp_payload.result_row);
               fail_count++;
            end
            if (rsp_payload.last !== wanted.last) begin
               $error("last: expected %0d, got %0d", wanted.last, rsp_payload.last);
               fail_count++;
            end
            if (rsp_payload.status !== wanted.status) begin
               $error("status: expected %0d, got %0d", wanted.status, rsp_payload.status);
               fail_count++;
            end
         end
      end
   end

   // send one request; valid stays high after acceptance until the next call or a drain
   task automatic send_request(input op_type op, input int r, input int c,
                               input logic [31:0] v);
      req_payload_type rq;
      rq.operation = op;
      rq.row_index = 4'(r);
      rq.column_index = 4'(c);
      rq.operand_value = v;
      @(negedge clock);
      while (!steady && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(rq);
   endtask

   // stop sending and wait for every queued response
   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_access(input logic is_write, input logic [CSR_AW-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
   endtask

   // write a register, read it back; a write clears the matrix and the collapse
   task automatic set_register(input logic which, input logic [4:0] value);
      logic [CSR_AW-1:0] addr;
      logic [31:0] rdata;
      addr = (which == REG_ROWS) ? ROWS_ADDR : COLS_ADDR;
      // let a clearing pass from an earlier write finish
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apb_access(1'b1, addr, 32'(value), rdata);
      if (which == REG_ROWS) rows_reg = value;
      else cols_reg = value;
      foreach (matrix_model[i]) matrix_model[i] = '0;
      collapsed = 1'b0;
      apb_access(1'b0, addr, '0, rdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (rdata[4:0] !== value) begin
         $error("register readback: expected %0d, got %0d", value, rdata[4:0]);
         fail_count++;
      end
   endtask

   function automatic logic [31:0] q_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0, 1, 2: v = {{14{v[17]}}, v[17:0]};
         3:       v = {{22{v[9]}}, v[9:0]};
         4:       v = 32'h7FFF_FFFF;
         5:       v = 32'h8000_0000;
         default: ;
      endcase
      return v;
   endfunction

   // mostly near +-1.0 so the matrix does not collapse to zero or saturate at once
   function automatic logic [31:0] scale_factor();
      logic [31:0] f;
      f = 32'($urandom_range(32'h1_8000, 32'h8000));
      if ($urandom_range(1)) f = -f;
      if ($urandom_range(4) == 0) f = q_value();
      return f;
   endfunction

   task automatic test_element_extremes();
      send_request(OP_WRITE, 0, 0, 32'h7FFF_FFFF);
      send_request(OP_WRITE, 15, 15, 32'h8000_0000);
      send_request(OP_READ, 15, 15, 32'h0);
      send_request(OP_READ, 0, 0, 32'hFFFF_FFFF);
      send_request(OP_READ, 7, 9, 32'h0);
   endtask

   // negative products round toward zero, large factors saturate
   task automatic test_scale_rounding();
      settle_block();
      set_register(REG_ROWS, 5'd2);
      set_register(REG_COLS, 5'd2);
      send_request(OP_WRITE, 0, 0, 32'hFFFF_FFFF);
      send_request(OP_WRITE, 0, 1, 32'h7FFF_FFFF);
      send_request(OP_WRITE, 1, 1, 32'h8000_0000);
      send_request(OP_SCALE, 15, 15, 32'h0000_8000);
      send_request(OP_READ, 0, 0, 32'h0);
      send_request(OP_SCALE, 9, 3, 32'h8000_0000);
      send_request(OP_READ, 0, 1, 32'h0);
      send_request(OP_READ, 1, 1, 32'h0);
   endtask

   task automatic test_index_range();
      send_request(OP_WRITE, 2, 0, 32'h1234_5678);
      send_request(OP_READ, 0, 2, 32'h0);
      send_request(OP_VECTOR, 0, 2, 32'h0001_0000);
      send_request(OP_READ, 15, 15, 32'h0);
   endtask

   // full vector gives one result per row, then the matrix is a single column
   task automatic test_product_and_collapse();
      send_request(OP_VECTOR, 9, 0, 32'h0000_C000);
      send_request(OP_VECTOR, 5, 1, 32'hFFFE_8000);
      send_request(OP_READ, 0, 1, 32'h0);
      send_request(OP_READ, 1, 0, 32'h0);
      send_request(OP_VECTOR, 14, 0, 32'h0002_0000);
   endtask

   // zero acts as one, values above the maximum act as the maximum
   task automatic test_register_clamp();
      settle_block();
      set_register(REG_ROWS, 5'd0);
      set_register(REG_COLS, 5'd31);
      send_request(OP_WRITE, 1, 0, 32'h0000_0001);
      send_request(OP_WRITE, 0, 15, 32'h0003_0000);
      settle_block();
      set_register(REG_ROWS, 5'd31);
      set_register(REG_COLS, 5'd0);
      send_request(OP_WRITE, 15, 0, 32'hFFFF_0000);
      send_request(OP_READ, 15, 1, 32'h0);
   endtask

   // random phases over several sizes; vectors mostly arrive in column order
   task automatic test_random_phases();
      int rows_set [PHASES] = '{1, 3, 16, 0, 4, 31, 2, 5, 16};
      int cols_set [PHASES] = '{1, 4, 2, 16, 3, 0, 31, 5, 16};
      int next_pos, pick, nr, nc, r, c, k;
      op_type op;
      logic [31:0] v;
      for (int ph = 0; ph < PHASES; ph++) begin
         settle_block();
         steady = (ph == 2 || ph == 3);
         set_register(REG_ROWS, 5'(rows_set[ph]));
         set_register(REG_COLS, 5'(cols_set[ph]));
         next_pos = 0;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n == PHASE_REQUESTS / 2) wait_results_done();
            nr = rows_eff();
            nc = cols_eff();
            pick = $urandom_range(99);
            r = $urandom_range(nr - 1);
            c = $urandom_range(nc - 1);
            if ($urandom_range(7) == 0) begin
               r = $urandom_range(15);
               c = $urandom_range(15);
            end
            v = q_value();
            if (pick < 28) op = OP_WRITE;
            else if (pick < 45) op = OP_READ;
            else if (pick < 53) begin
               op = OP_SCALE;
               r = $urandom_range(15);
               c = $urandom_range(15);
               v = scale_factor();
            end else begin
               op = OP_VECTOR;
               r = $urandom_range(15);
               if (next_pos >= nc) next_pos = 0;
               if ($urandom_range(7) != 0) c = next_pos;
               else c = $urandom_range(15);
               // never complete a vector over positions not yet written
               if (c == nc - 1) begin
                  k = 0;
                  while (k < nc - 1 && vector_written[k]) k++;
                  c = k;
               end
               if (c < nc) next_pos = c + 1;
            end
            send_request(op, r, c, v);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      foreach (matrix_model[i]) matrix_model[i] = '0;
      foreach (vector_model[i]) vector_model[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_element_extremes();
      test_scale_rounding();
      test_index_range();
      test_product_and_collapse();
      test_register_clamp();
      test_random_phases();
      settle_block();
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("matrix_scale_and_matvec test passed");
      end else begin
         $display("matrix_scale_and_matvec test failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("matrix_scale_and_matvec test failed");
      $finish;
   end

endmodule
